// ----- design/hffp_pkg.sv -----
// package with shared constants and types of the height map first fit placer
`timescale 1ns / 1ps
`default_nettype none
package hffp_pkg;
    localparam int MAP_LENGTH_DEF  = 32;
    localparam int MAP_WIDTH_DEF   = 32;
    localparam int HEIGHT_BITS_DEF = 8;

    localparam logic [1:0] CMD_QUERY = 2'd0;
    localparam logic [1:0] CMD_PLACE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] ST_FIT      = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_DONE     = 2'd2;
    localparam logic [1:0] ST_REJECTED = 2'd3;

    localparam logic [7:0] CONTAINER_HEIGHT_RESET = 8'd64;

    typedef struct packed {
        logic [1:0] command;
        logic [4:0] pos_x;
        logic [4:0] pos_y;
        logic [7:0] pos_z;
        logic [5:0] size_x;
        logic [5:0] size_y;
        logic [7:0] size_z;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  fit_x;
        logic [4:0]  fit_y;
        logic [7:0]  fit_z;
        logic [10:0] support_count;
    } res_t;
endpackage
`default_nettype wire

// ----- design/hffp_stream_if.sv -----
// valid ready channel interface carrying a payload
`timescale 1ns / 1ps
`default_nettype none
interface hffp_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/heightmap_first_fit_placer.sv -----
// top level of the height map first fit placer
//
// channel   dir  payload
// cmd_in    in   command, pos_x/y/z, size_x/y/z
// res_out   out  status, fit_x/y/z, support_count
// cfg       in   cfg_we, cfg_wdata: container_height
//
// one item at a time; the height map sits in a single port ram, one cell per cycle
// query: per corner sx*sy reads, then S_QLAST folds the last read and S_QEVAL tests the corner
// place and clear write their cells in turn, clear walks all L*W cells
// after reset a clearing pass over all L*W cells runs before the first transfer is taken
// the result waits in an output register; input is taken again once it is sent
`timescale 1ns / 1ps
`default_nettype none
module heightmap_first_fit_placer #(
    parameter int MAP_LENGTH  = hffp_pkg::MAP_LENGTH_DEF,
    parameter int MAP_WIDTH   = hffp_pkg::MAP_WIDTH_DEF,
    parameter int HEIGHT_BITS = hffp_pkg::HEIGHT_BITS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,
    hffp_stream_if.sink     cmd_in,
    hffp_stream_if.source   res_out
);
    localparam int CELLS = MAP_LENGTH * MAP_WIDTH;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int XW    = (MAP_LENGTH > 1) ? $clog2(MAP_LENGTH) : 1;
    localparam int YW    = (MAP_WIDTH > 1) ? $clog2(MAP_WIDTH) : 1;
    localparam int HW    = HEIGHT_BITS;
    localparam int CW    = 12;
    localparam logic [HW:0] HMAX = {1'b0, {HW{1'b1}}};

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_QRD   = 3'd2;
    localparam logic [2:0] S_QEVAL = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;
    localparam logic [2:0] S_QLAST = 3'd6;

    logic [2:0]      state_reg, state_next;
    logic [7:0]      ch_reg;
    hffp_pkg::cmd_t  cmd_reg;
    hffp_pkg::res_t  res_reg, res_next;
    logic [8:0]      bx_reg, bx_next, by_reg, by_next;
    logic [8:0]      ci_reg, ci_next, cj_reg, cj_next;
    logic [HW-1:0]   peak_reg, peak_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [AW:0]     wcnt_reg, wcnt_next;
    logic            rvalid_reg, rvalid_next;
    logic            we;
    logic [AW-1:0]   addr;
    logic [HW-1:0]   wdata, rdata;
    logic [HW-1:0]   fill_reg, fill_next;

    logic [6:0]      sx, sy;
    logic [17:0]     area3;
    logic [HW-1:0]   np;
    logic [CW-1:0]   nc;
    logic [17:0]     cellidx;

    hffp_ram #(.WIDTH(HW), .DEPTH(CELLS)) u_map (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    assign sx      = {1'b0, cmd_reg.size_x};
    assign sy      = {1'b0, cmd_reg.size_y};
    assign area3   = 18'(sx) * 18'(sy) * 18'd3;
    assign cellidx = 18'(ci_reg) * 18'(MAP_WIDTH) + 18'(cj_reg);
    assign cmd_in.ready = (state_reg == S_IDLE);
    assign res_out.valid = (state_reg == S_OUT);
    assign res_out.data  = res_reg;

    always_comb
    begin
        if (!rvalid_reg || rdata > peak_reg)
        begin
            np = rdata;
            nc = CW'(1);
        end
        else
        begin
            np = peak_reg;
            nc = cnt_reg + ((rdata == peak_reg) ? CW'(1) : CW'(0));
        end
        if (!rvalid_reg)
        begin
            np = peak_reg;
            nc = cnt_reg;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        res_next    = res_reg;
        bx_next     = bx_reg;
        by_next     = by_reg;
        ci_next     = ci_reg;
        cj_next     = cj_reg;
        peak_next   = peak_reg;
        cnt_next    = cnt_reg;
        wcnt_next   = wcnt_reg;
        rvalid_next = 1'b0;
        fill_next   = fill_reg;
        we          = 1'b0;
        addr        = cellidx[AW-1:0];
        wdata       = fill_reg;
        case (state_reg)
            S_INIT, S_WRITE:
            begin
                if (wcnt_reg == (AW + 1)'(0))
                begin
                    we   = 1'b1;
                    addr = wcnt_reg[AW-1:0];
                    if (state_reg == S_INIT)
                    begin
                        addr = {AW{1'b0}};
                    end
                end
                if (cmd_reg.command == hffp_pkg::CMD_PLACE && state_reg == S_WRITE)
                begin
                    we   = 1'b1;
                    addr = cellidx[AW-1:0];
                    if (cj_reg + 9'd1 < by_reg + 9'(sy))
                    begin
                        cj_next = cj_reg + 9'd1;
                    end
                    else
                    begin
                        cj_next = by_reg;
                        ci_next = ci_reg + 9'd1;
                        if (ci_reg + 9'd1 >= bx_reg + 9'(sx))
                        begin
                            state_next = S_OUT;
                        end
                    end
                end
                else
                begin
                    we   = 1'b1;
                    addr = wcnt_reg[AW-1:0];
                    wcnt_next = wcnt_reg + (AW + 1)'(1);
                    if (wcnt_reg == (AW + 1)'(CELLS - 1))
                    begin
                        state_next = (state_reg == S_INIT) ? S_IDLE : S_OUT;
                    end
                end
            end
            S_IDLE:
            begin
                if (cmd_in.valid)
                begin
                    res_next  = '0;
                    wcnt_next = '0;
                    fill_next = '0;
                    bx_next   = '0;
                    by_next   = '0;
                    state_next = S_OUT;
                    case (cmd_in.data.command)
                        hffp_pkg::CMD_QUERY:
                        begin
                            res_next.status = hffp_pkg::ST_NO_FIT;
                            if (cmd_in.data.size_x != '0 && cmd_in.data.size_y != '0
                                && cmd_in.data.size_z != '0
                                && 32'(cmd_in.data.size_x) <= MAP_LENGTH
                                && 32'(cmd_in.data.size_y) <= MAP_WIDTH)
                            begin
                                ci_next   = '0;
                                cj_next   = '0;
                                peak_next = '0;
                                cnt_next  = '0;
                                state_next = S_QRD;
                            end
                        end
                        hffp_pkg::CMD_PLACE:
                        begin
                            res_next.status = hffp_pkg::ST_REJECTED;
                            bx_next = 9'(cmd_in.data.pos_x);
                            by_next = 9'(cmd_in.data.pos_y);
                            ci_next = 9'(cmd_in.data.pos_x);
                            cj_next = 9'(cmd_in.data.pos_y);
                            fill_next = HW'((HW + 1)'(cmd_in.data.pos_z)
                                + (HW + 1)'(cmd_in.data.size_z));
                            if (cmd_in.data.size_x != '0 && cmd_in.data.size_y != '0
                                && 32'(cmd_in.data.pos_x) + 32'(cmd_in.data.size_x)
                                   <= MAP_LENGTH
                                && 32'(cmd_in.data.pos_y) + 32'(cmd_in.data.size_y)
                                   <= MAP_WIDTH
                                && 17'(cmd_in.data.pos_z) + 17'(cmd_in.data.size_z)
                                   <= 17'(HMAX))
                            begin
                                res_next.status = hffp_pkg::ST_DONE;
                                state_next = S_WRITE;
                            end
                        end
                        hffp_pkg::CMD_CLEAR:
                        begin
                            res_next.status = hffp_pkg::ST_DONE;
                            state_next = S_WRITE;
                        end
                        default:
                        begin
                            res_next.status = hffp_pkg::ST_REJECTED;
                        end
                    endcase
                end
            end
            S_QRD:
            begin
                // issue footprint read, fold the previous read data
                peak_next   = np;
                cnt_next    = nc;
                ci_next     = ci_reg;
                rvalid_next = 1'b1;
                if (cj_reg + 9'd1 < by_reg + 9'(sy))
                begin
                    cj_next = cj_reg + 9'd1;
                end
                else
                begin
                    cj_next = by_reg;
                    ci_next = ci_reg + 9'd1;
                    if (ci_reg + 9'd1 >= bx_reg + 9'(sx))
                    begin
                        state_next = S_QLAST;
                    end
                end
                if (ci_reg == bx_reg && cj_reg == by_reg)
                begin
                    peak_next = '0;
                    cnt_next  = '0;
                end
            end
            S_QLAST:
            begin
                peak_next = np;
                cnt_next  = nc;
                state_next = S_QEVAL;
            end
            S_QEVAL:
            begin
                peak_next = '0;
                cnt_next  = '0;
                if ((HW + 1)'(peak_reg) + (HW + 1)'(cmd_reg.size_z) <= (HW + 1)'(ch_reg)
                    && 18'(cnt_reg) * 18'd4 >= area3)
                begin
                    res_next.status        = hffp_pkg::ST_FIT;
                    res_next.fit_x         = 5'(bx_reg);
                    res_next.fit_y         = 5'(by_reg);
                    res_next.fit_z         = 8'(peak_reg);
                    res_next.support_count = 11'(cnt_reg);
                    state_next = S_OUT;
                end
                else if (32'(by_reg) + 32'(sy) < MAP_WIDTH)
                begin
                    by_next = by_reg + 9'd1;
                    ci_next = bx_reg;
                    cj_next = by_reg + 9'd1;
                    state_next = S_QRD;
                end
                else if (32'(bx_reg) + 32'(sx) < MAP_LENGTH)
                begin
                    bx_next = bx_reg + 9'd1;
                    by_next = '0;
                    ci_next = bx_reg + 9'd1;
                    cj_next = '0;
                    state_next = S_QRD;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (res_out.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            ch_reg     <= hffp_pkg::CONTAINER_HEIGHT_RESET;
            wcnt_reg   <= '0;
            rvalid_reg <= 1'b0;
            fill_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            wcnt_reg   <= wcnt_next;
            rvalid_reg <= rvalid_next;
            fill_reg   <= fill_next;
            if (cfg_we)
            begin
                ch_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_in.valid)
        begin
            cmd_reg <= cmd_in.data;
        end
        res_reg  <= res_next;
        bx_reg   <= bx_next;
        by_reg   <= by_next;
        ci_reg   <= ci_next;
        cj_reg   <= cj_next;
        peak_reg <= peak_next;
        cnt_reg  <= cnt_next;
    end
endmodule
`default_nettype wire

// ----- design/hffp_ram.sv -----
// generic single port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module hffp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ----- tb/sv/heightmap_first_fit_placer_tb.sv -----
// self-checking testbench of the height map first fit placer with a scoreboard class
`timescale 1ns / 1ps
module heightmap_first_fit_placer_tb;

    class placer_scoreboard;
        bit [7:0]       cells [32][32];
        bit [7:0]       ceiling;
        hffp_pkg::res_t pending [$];
        int             errors;

        function new();
            ceiling = hffp_pkg::CONTAINER_HEIGHT_RESET;
            errors = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (cells[i, j])
                cells[i][j] = 8'd0;
        endfunction

        function hffp_pkg::res_t first_fit(hffp_pkg::cmd_t c);
            hffp_pkg::res_t r;
            int sx, sy, sz, peak, cnt;
            r = '0;
            r.status = hffp_pkg::ST_NO_FIT;
            sx = c.size_x;
            sy = c.size_y;
            sz = c.size_z;
            if (sx == 0 || sy == 0 || sz == 0 || sx > 32 || sy > 32)
                return r;
            for (int x = 0; x + sx <= 32; x++)
            begin
                for (int y = 0; y + sy <= 32; y++)
                begin
                    peak = 0;
                    cnt = 0;
                    for (int i = x; i < x + sx; i++)
                    begin
                        for (int j = y; j < y + sy; j++)
                        begin
                            if (cells[i][j] > peak)
                            begin
                                peak = cells[i][j];
                                cnt = 1;
                            end
                            else if (cells[i][j] == peak)
                            begin
                                cnt++;
                            end
                        end
                    end
                    if (peak + sz > ceiling)
                        continue;
                    if (4 * cnt >= 3 * sx * sy)
                    begin
                        r.status = hffp_pkg::ST_FIT;
                        r.fit_x = 5'(x);
                        r.fit_y = 5'(y);
                        r.fit_z = 8'(peak);
                        r.support_count = 11'(cnt);
                        return r;
                    end
                end
            end
            return r;
        endfunction

        function void note(hffp_pkg::cmd_t c);
            hffp_pkg::res_t r;
            int top;
            r = '0;
            top = int'(c.pos_z) + int'(c.size_z);
            case (c.command)
                hffp_pkg::CMD_QUERY: r = first_fit(c);
                hffp_pkg::CMD_PLACE:
                begin
                    if (c.size_x == 0 || c.size_y == 0 || c.pos_x + c.size_x > 32 ||
                        c.pos_y + c.size_y > 32 || top > 255)
                    begin
                        r.status = hffp_pkg::ST_REJECTED;
                    end
                    else
                    begin
                        for (int i = c.pos_x; i < c.pos_x + c.size_x; i++)
                            for (int j = c.pos_y; j < c.pos_y + c.size_y; j++)
                                cells[i][j] = 8'(top);
                        r.status = hffp_pkg::ST_DONE;
                    end
                end
                hffp_pkg::CMD_CLEAR:
                begin
                    wipe();
                    r.status = hffp_pkg::ST_DONE;
                end
                default: r.status = hffp_pkg::ST_REJECTED;
            endcase
            pending = {pending, r};
        endfunction

        function void check(hffp_pkg::res_t a);
            hffp_pkg::res_t e;
            if (pending.size() == 0)
            begin
                errors++;
                $error("result transfer with nothing expected: status %0d", a.status);
                return;
            end
            e = pending.pop_front();
            if (a.status !== e.status)
            begin
                errors++;
                $error("status expected %0d actual %0d", e.status, a.status);
            end
            if (a.fit_x !== e.fit_x)
            begin
                errors++;
                $error("fit_x expected %0d actual %0d", e.fit_x, a.fit_x);
            end
            if (a.fit_y !== e.fit_y)
            begin
                errors++;
                $error("fit_y expected %0d actual %0d", e.fit_y, a.fit_y);
            end
            if (a.fit_z !== e.fit_z)
            begin
                errors++;
                $error("fit_z expected %0d actual %0d", e.fit_z, a.fit_z);
            end
            if (a.support_count !== e.support_count)
            begin
                errors++;
                $error("support_count expected %0d actual %0d", e.support_count,
                       a.support_count);
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [7:0] cfg_wdata = 8'd0;
    bit         send_quiet = 1'b0;
    bit         recv_quiet = 1'b0;
    bit         hold_req = 1'b0;

    placer_scoreboard sb = new();

    hffp_stream_if #(.payload_t(hffp_pkg::cmd_t)) cmd_if ();
    hffp_stream_if #(.payload_t(hffp_pkg::res_t)) res_if ();

    heightmap_first_fit_placer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_in    (cmd_if),
        .res_out   (res_if)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #1000000000;
        $display("simulation failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            sb.check(res_if.data);
    end

    // result side: random hold-offs, one long hold on request
    initial
    begin
        int w;
        res_if.ready <= 1'b0;
        forever
        begin
            if ($urandom_range(0, 19) == 0)
                recv_quiet = !recv_quiet;
            if (hold_req)
            begin
                hold_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else
            begin
                w = recv_quiet ? 0 : $urandom_range(0, 13);
                if (w > 0)
                begin
                    res_if.ready <= 1'b0;
                    repeat (w) @(posedge clk);
                end
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
            while (!(res_if.valid && rst_n))
                @(posedge clk);
        end
    end

    function automatic hffp_pkg::cmd_t mk(logic [1:0] c, int px, int py, int pz,
                                          int sx, int sy, int sz);
        hffp_pkg::cmd_t t;
        t.command = c;
        t.pos_x = 5'(px);
        t.pos_y = 5'(py);
        t.pos_z = 8'(pz);
        t.size_x = 6'(sx);
        t.size_y = 6'(sy);
        t.size_z = 8'(sz);
        return t;
    endfunction

    task automatic send(hffp_pkg::cmd_t c);
        int gap;
        if ($urandom_range(0, 19) == 0)
            send_quiet = !send_quiet;
        gap = send_quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.data <= c;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        sb.note(c);
    endtask

    task automatic drain();
        cmd_if.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_height(logic [7:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.ceiling = v;
    endtask

    task automatic run_random(int n);
        hffp_pkg::cmd_t q;
        hffp_pkg::res_t r;
        int k, sx, sy;
        for (int m = 0; m < n; m++)
        begin
            k = $urandom_range(0, 99);
            if (k < 45)
            begin
                // query then stack at the reported corner
                sx = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 10)
                                                 : $urandom_range(1, 4);
                sy = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 10)
                                                 : $urandom_range(1, 4);
                q = mk(hffp_pkg::CMD_QUERY, $urandom_range(0, 31), $urandom_range(0, 31),
                       $urandom_range(0, 255), sx, sy, $urandom_range(1, 40));
                r = sb.first_fit(q);
                send(q);
                if (r.status == hffp_pkg::ST_FIT)
                    send(mk(hffp_pkg::CMD_PLACE, r.fit_x, r.fit_y, r.fit_z, sx, sy,
                            q.size_z));
            end
            else if (k < 60)
            begin
                sx = $urandom_range(1, 6);
                sy = $urandom_range(1, 6);
                send(mk(hffp_pkg::CMD_PLACE, $urandom_range(0, 32 - sx),
                        $urandom_range(0, 32 - sy), $urandom_range(0, 200), sx, sy,
                        $urandom_range(1, 55)));
            end
            else if (k < 75)
            begin
                send(mk(hffp_pkg::CMD_QUERY, $urandom_range(0, 31), $urandom_range(0, 31),
                        $urandom_range(0, 255), $urandom_range(1, 8), $urandom_range(1, 8),
                        $urandom_range(1, 255)));
            end
            else if (k < 80)
            begin
                send(mk(hffp_pkg::CMD_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31),
                        $urandom_range(0, 255), $urandom_range(0, 63), $urandom_range(0, 63),
                        $urandom_range(0, 255)));
            end
            else if (k < 85)
            begin
                send(mk(2'd3, $urandom_range(0, 31), $urandom_range(0, 31),
                        $urandom_range(0, 255), $urandom_range(0, 63), $urandom_range(0, 63),
                        $urandom_range(0, 255)));
            end
            else
            begin
                send(mk(2'($urandom_range(0, 3)), $urandom_range(0, 31),
                        $urandom_range(0, 31), $urandom_range(0, 255),
                        $urandom_range(0, 63), $urandom_range(0, 63),
                        $urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        cmd_if.valid <= 1'b0;
        cmd_if.data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at the reset height
        send(mk(hffp_pkg::CMD_QUERY, 0, 0, 0, 1, 1, 1));
        send(mk(hffp_pkg::CMD_QUERY, 31, 31, 255, 32, 32, 64));
        send(mk(hffp_pkg::CMD_QUERY, 0, 0, 0, 32, 32, 65));
        send(mk(hffp_pkg::CMD_QUERY, 0, 0, 0, 33, 1, 1));
        send(mk(hffp_pkg::CMD_QUERY, 0, 0, 0, 0, 4, 4));
        send(mk(hffp_pkg::CMD_QUERY, 0, 0, 0, 4, 0, 4));
        send(mk(hffp_pkg::CMD_QUERY, 0, 0, 0, 4, 4, 0));
        send(mk(hffp_pkg::CMD_PLACE, 0, 0, 0, 32, 32, 10));
        send(mk(hffp_pkg::CMD_PLACE, 31, 0, 0, 2, 1, 1));
        send(mk(hffp_pkg::CMD_PLACE, 0, 31, 0, 1, 2, 1));
        send(mk(hffp_pkg::CMD_PLACE, 0, 0, 250, 1, 1, 10));
        send(mk(hffp_pkg::CMD_PLACE, 0, 0, 0, 0, 1, 1));
        send(mk(hffp_pkg::CMD_PLACE, 0, 0, 0, 1, 0, 1));
        send(mk(hffp_pkg::CMD_PLACE, 31, 31, 255, 1, 1, 0));
        send(mk(2'd3, 31, 31, 255, 63, 63, 255));
        send(mk(hffp_pkg::CMD_QUERY, 0, 0, 0, 2, 2, 1));
        send(mk(hffp_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0));
        send(mk(hffp_pkg::CMD_PLACE, 0, 0, 5, 2, 2, 5));
        send(mk(hffp_pkg::CMD_PLACE, 0, 0, 0, 1, 1, 20));
        send(mk(hffp_pkg::CMD_QUERY, 0, 0, 0, 2, 2, 1));
        send(mk(hffp_pkg::CMD_QUERY, 0, 0, 0, 4, 4, 1));
        send(mk(hffp_pkg::CMD_QUERY, 0, 0, 0, 63, 63, 255));
        send(mk(hffp_pkg::CMD_QUERY, 0, 0, 0, 16, 16, 1));

        set_height(8'd255);
        run_random(20);
        hold_req = 1'b1;
        run_random(14);

        set_height(8'd1);
        send(mk(hffp_pkg::CMD_QUERY, 0, 0, 0, 1, 1, 1));
        send(mk(hffp_pkg::CMD_QUERY, 0, 0, 0, 1, 1, 2));
        run_random(8);

        set_height(8'd0);
        send(mk(hffp_pkg::CMD_QUERY, 0, 0, 0, 1, 1, 1));
        run_random(6);

        set_height(8'($urandom_range(1, 255)));
        run_random(16);

        set_height(8'd200);
        run_random(16);

        drain();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
